[rtl/core/rating_mean_median_mode_unit_macros.svh]
// Assertion macros shared by the checker of the rating statistics unit.
`ifndef RATING_MEAN_MEDIAN_MODE_UNIT_MACROS_SVH
`define RATING_MEAN_MEDIAN_MODE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RMMM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmmm checker: same-cycle property failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define RMMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmmm checker: next-cycle property failed");

`endif

[rtl/core/rmmm_pkg.sv]
// Types and constants of the rating statistics unit.
`default_nettype none

package rmmm_pkg;

    localparam int NUM_BINS   = 9;
    localparam int BIN_W      = 4;
    localparam int RATING_W   = 4;
    localparam int MEAN_W     = 12;
    localparam int FRAC_W     = 8;
    localparam int MODE_CNT_W = 11;
    localparam int SUM_OUT_W  = 14;
    localparam int ITEM_OUT_W = 11;

    localparam logic [RATING_W-1:0] RATING_MIN = 4'd1;
    localparam logic [RATING_W-1:0] RATING_MAX = 4'd9;

    typedef struct packed {
        logic [RATING_W-1:0] rating;
        logic                last_item;
    } rmmm_in_t;

    typedef struct packed {
        logic [MEAN_W-1:0]     mean_fixed;
        logic [RATING_W-1:0]   median_value;
        logic [RATING_W-1:0]   mode_value;
        logic [MODE_CNT_W-1:0] mode_count;
        logic [SUM_OUT_W-1:0]  sum_total;
        logic [ITEM_OUT_W-1:0] item_total;
    } rmmm_out_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_LOAD,
        ST_CALC
    } rmmm_state_t;

endpackage

`default_nettype wire

[rtl/core/rmmm_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module rmmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A read at the same edge as a write to that entry returns the old data.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/rmmm_div.sv]
// Restoring divider that forms sum * 256 / count, one quotient bit per cycle.
`default_nettype none

module rmmm_div
    import rmmm_pkg::*;
#(
    parameter int SUM_W = 14,
    parameter int CNT_W = 11
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SUM_W-1:0]  sum,
    input  wire logic [CNT_W-1:0]  cnt,
    output logic                   busy,
    output logic [MEAN_W-1:0]      quotient
);

    localparam int LOW_W  = MEAN_W - FRAC_W;
    localparam int STEP_W = $clog2(MEAN_W + 1);

    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [MEAN_W-1:0] dvd_reg, dvd_next;
    logic [MEAN_W-1:0] quo_reg, quo_next;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_sub;
    logic              fits;

    always_comb
    begin
        step_next = step_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_sh    = {rem_reg, dvd_reg[MEAN_W-1]};
        rem_sub   = rem_sh - {1'b0, dsr_reg};
        fits      = (rem_sh >= {1'b0, dsr_reg});
        if (start)
        begin
            // The quotient stays below 4096, so the top part of the dividend
            // is already smaller than the divisor.
            step_next = STEP_W'(MEAN_W);
            rem_next  = CNT_W'(sum >> LOW_W);
            dsr_next  = cnt;
            dvd_next  = {sum[LOW_W-1:0], {FRAC_W{1'b0}}};
            quo_next  = '0;
        end
        else if (step_reg != '0)
        begin
            step_next = step_reg - STEP_W'(1);
            rem_next  = fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            dvd_next  = {dvd_reg[MEAN_W-2:0], 1'b0};
            quo_next  = {quo_reg[MEAN_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign busy     = (step_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/core/rating_mean_median_mode_unit.sv]
// Top level of the rating statistics unit: histogram RAM, run control and result register.
//
// Usage:
//   Input beats carry one rating (1 to 9) and a last_item flag on in_valid/in_ready.
//   Ratings outside 1..9, and ratings beyond MAX_ITEMS in one run, are not counted,
//   but a last_item flag on them still closes the run.
//   While a run loads, one rating is taken every cycle; each one does a
//   read-modify-write of its bin in the histogram RAM, with forwarding between
//   back-to-back beats to the same bin.
//   The beat with last_item set starts the closing phase: the divider forms the
//   mean while the 9 bins are read in turn for median and mode and written back as zero.
//   The result beat is registered once the divider and the bin walk are done; in_ready is
//   low throughout the closing phase, so the next run is not taken until it ends.
//   The result waits in the output register on out_valid/out_ready, and the next run
//   loads while it waits. If the receiver still stalls when the next run closes, the
//   block holds its closing phase with in_ready low until the output register is free.
//   After reset the histogram RAM is cleared bin by bin with in_ready low.
//   An empty run returns a result with every field zero.
`default_nettype none

module rating_mean_median_mode_unit
    import rmmm_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire rmmm_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output rmmm_out_t      out_data
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = $clog2(NUM_BINS * MAX_ITEMS + 1);

    rmmm_state_t state_reg, state_next;

    logic [BIN_W-1:0]    idx_reg, idx_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0]    tot_sum_reg, tot_sum_next;
    logic [CNT_W-1:0]    tot_cnt_reg, tot_cnt_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                rd_walk_reg, rd_walk_next;
    logic [BIN_W-1:0]    rd_addr_reg, rd_addr_next;
    logic                fwd_valid_reg;
    logic [BIN_W-1:0]    fwd_addr_reg;
    logic [CNT_W-1:0]    fwd_data_reg;
    logic [CNT_W-1:0]    cum_reg, cum_next;
    logic                found_reg, found_next;
    logic [RATING_W-1:0] med_reg, med_next;
    logic [CNT_W-1:0]    mcnt_reg, mcnt_next;
    logic [RATING_W-1:0] mval_reg, mval_next;
    logic                out_valid_reg, out_valid_next;
    rmmm_out_t           out_reg, out_next;

    logic                ram_we;
    logic [BIN_W-1:0]    ram_waddr;
    logic [CNT_W-1:0]    ram_wdata;
    logic [BIN_W-1:0]    ram_raddr;
    logic [CNT_W-1:0]    ram_rdata;

    logic                in_fire;
    logic                rate_ok;
    logic [BIN_W-1:0]    in_bin;
    logic [SUM_W-1:0]    sum_upd;
    logic [CNT_W-1:0]    cnt_upd;
    logic [CNT_W-1:0]    bin_val;
    logic [CNT_W-1:0]    cum_add;
    logic                walk_done;
    logic                out_free;
    logic                div_start;
    logic                div_busy;
    logic [MEAN_W-1:0]   div_quo;

    rmmm_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BINS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rmmm_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .sum      (sum_upd),
        .cnt      (cnt_upd),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    assign in_ready  = (state_reg == ST_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign rate_ok   = (in_data.rating >= RATING_MIN) && (in_data.rating <= RATING_MAX)
                       && (cnt_reg < CNT_W'(MAX_ITEMS));
    assign in_bin    = BIN_W'(in_data.rating - RATING_MIN);
    assign sum_upd   = rate_ok ? (sum_reg + SUM_W'(in_data.rating)) : sum_reg;
    assign cnt_upd   = rate_ok ? (cnt_reg + CNT_W'(1)) : cnt_reg;

    // The entry written at the previous edge is not yet in the read data.
    assign bin_val   = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_data_reg
                                                                         : ram_rdata;
    assign cum_add   = cum_reg + bin_val;
    assign walk_done = (idx_reg == BIN_W'(NUM_BINS)) && !rd_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        tot_sum_next   = tot_sum_reg;
        tot_cnt_next   = tot_cnt_reg;
        rd_valid_next  = 1'b0;
        rd_walk_next   = 1'b0;
        rd_addr_next   = rd_addr_reg;
        cum_next       = cum_reg;
        found_next     = found_reg;
        med_next       = med_reg;
        mcnt_next      = mcnt_reg;
        mval_next      = mval_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        div_start      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = rd_addr_reg;
        ram_wdata      = '0;
        ram_raddr      = idx_reg;

        // Write back the bin read in the previous cycle: increment or clear.
        if (rd_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = rd_addr_reg;
            ram_wdata = rd_walk_reg ? '0 : (bin_val + CNT_W'(1));
        end

        if (rd_valid_reg && rd_walk_reg)
        begin
            cum_next = cum_add;
            if (!found_reg && (cum_add > (tot_cnt_reg >> 1)))
            begin
                found_next = 1'b1;
                med_next   = RATING_W'(rd_addr_reg) + RATING_W'(1);
            end
            // Strictly greater, so a tie keeps the lower rating.
            if (bin_val > mcnt_reg)
            begin
                mcnt_next = bin_val;
                mval_next = RATING_W'(rd_addr_reg) + RATING_W'(1);
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = '0;
                if (idx_reg == BIN_W'(NUM_BINS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    idx_next = idx_reg + BIN_W'(1);
                end
            end
            ST_LOAD:
            begin
                ram_raddr = in_bin;
                if (in_fire)
                begin
                    if (rate_ok)
                    begin
                        rd_valid_next = 1'b1;
                        rd_addr_next  = in_bin;
                    end
                    sum_next = sum_upd;
                    cnt_next = cnt_upd;
                    if (in_data.last_item)
                    begin
                        tot_sum_next = sum_upd;
                        tot_cnt_next = cnt_upd;
                        sum_next     = '0;
                        cnt_next     = '0;
                        div_start    = 1'b1;
                        idx_next     = '0;
                        cum_next     = '0;
                        found_next   = 1'b0;
                        med_next     = '0;
                        mcnt_next    = '0;
                        mval_next    = '0;
                        state_next   = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                if (idx_reg != BIN_W'(NUM_BINS))
                begin
                    ram_raddr     = idx_reg;
                    rd_valid_next = 1'b1;
                    rd_walk_next  = 1'b1;
                    rd_addr_next  = idx_reg;
                    idx_next      = idx_reg + BIN_W'(1);
                end
                else if (walk_done && !div_busy && out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.mean_fixed   = (tot_cnt_reg == '0) ? '0 : div_quo;
                    out_next.median_value = med_reg;
                    out_next.mode_value   = mval_reg;
                    out_next.mode_count   = MODE_CNT_W'(mcnt_reg);
                    out_next.sum_total    = SUM_OUT_W'(tot_sum_reg);
                    out_next.item_total   = ITEM_OUT_W'(tot_cnt_reg);
                    state_next            = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_INIT;
                idx_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            rd_valid_reg  <= rd_valid_next;
            fwd_valid_reg <= ram_we;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tot_sum_reg  <= tot_sum_next;
        tot_cnt_reg  <= tot_cnt_next;
        rd_walk_reg  <= rd_walk_next;
        rd_addr_reg  <= rd_addr_next;
        fwd_addr_reg <= ram_waddr;
        fwd_data_reg <= ram_wdata;
        cum_reg      <= cum_next;
        found_reg    <= found_next;
        med_reg      <= med_next;
        mcnt_reg     <= mcnt_next;
        mval_reg     <= mval_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

[rtl/core/rmmm_checker.sv]
// Port-level checker of the rating statistics unit and its bind to the top level.
`default_nettype none

`include "rating_mean_median_mode_unit_macros.svh"

module rmmm_checker
    import rmmm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_ready,
    input  wire rmmm_in_t  in_data,
    input  wire logic      out_valid,
    input  wire logic      out_ready,
    input  wire rmmm_out_t out_data
);

    // A stalled result beat keeps its value.
    `RMMM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // The closing beat of a run is followed by the closing phase, which takes no beat.
    `RMMM_ASSERT_NEXT(a_close_blocks, in_valid && in_ready && in_data.last_item, !in_ready)

    // An empty run, and only an empty run, has a zero total.
    `RMMM_ASSERT_SAME(a_empty_run, out_valid,
        (out_data.item_total == '0) == (out_data.sum_total == '0))

    // A nonempty run has a median and a mode inside the rating range.
    `RMMM_ASSERT_SAME(a_stats_range, out_valid && (out_data.item_total != '0),
        (out_data.median_value >= RATING_MIN) && (out_data.median_value <= RATING_MAX)
        && (out_data.mode_value >= RATING_MIN) && (out_data.mode_value <= RATING_MAX))

    // The mode cannot occur more often than the run has beats.
    `RMMM_ASSERT_SAME(a_mode_count, out_valid,
        ITEM_OUT_W'(out_data.mode_count) <= out_data.item_total)

endmodule

bind rating_mean_median_mode_unit rmmm_checker u_rmmm_checker (.*);

`default_nettype wire

[sim/rating_mean_median_mode_unit_checker.sv]
// Checker for the rating statistics unit: predicts each run summary and compares the result beats.
`timescale 1ns / 1ps

module rating_mean_median_mode_unit_checker
    import rmmm_pkg::*;
#(
    parameter int MAX_ITEMS = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  rmmm_in_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  rmmm_out_t out_data,
    output int        mismatch_total,
    output int        owed_results
);

    logic [MODE_CNT_W-1:0] hist_bins [NUM_BINS];
    logic [SUM_OUT_W-1:0]  rating_sum;
    logic [ITEM_OUT_W-1:0] rating_count;
    rmmm_out_t             pending_summaries [$];

    function automatic void clear_run();
        for (int b = 0; b < NUM_BINS; b++)
        begin
            hist_bins[b] = '0;
        end
        rating_sum   = '0;
        rating_count = '0;
    endfunction

    // Median is the first rating whose cumulative count passes half the run;
    // the mode only moves on a strictly larger bin, so the lower rating keeps a tie.
    function automatic rmmm_out_t summarize_run();
        rmmm_out_t             s;
        logic [21:0]           quotient;
        logic [ITEM_OUT_W-1:0] half;
        logic [ITEM_OUT_W:0]   cum;
        bit                    found;
        s     = '0;
        found = 1'b0;
        cum   = '0;
        if (rating_count != 0)
        begin
            quotient   = {rating_sum, 8'b0} / rating_count;
            s.mean_fixed = quotient[MEAN_W-1:0];
            half = rating_count >> 1;
            for (int b = 0; b < NUM_BINS; b++)
            begin
                cum += hist_bins[b];
                if (!found && cum > half)
                begin
                    s.median_value = RATING_W'(b + 1);
                    found = 1'b1;
                end
                if (hist_bins[b] > s.mode_count)
                begin
                    s.mode_count = hist_bins[b];
                    s.mode_value = RATING_W'(b + 1);
                end
            end
        end
        s.sum_total  = rating_sum;
        s.item_total = rating_count;
        return s;
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatch_total++;
            if (mismatch_total <= 10)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        rmmm_out_t want;
        if (!rst_n)
        begin
            clear_run();
            pending_summaries.delete();
            mismatch_total = 0;
            owed_results <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (in_data.rating >= RATING_MIN && in_data.rating <= RATING_MAX &&
                    rating_count < MAX_ITEMS)
                begin
                    hist_bins[in_data.rating - 1] += 1'b1;
                    rating_sum   += in_data.rating;
                    rating_count += 1'b1;
                end
                if (in_data.last_item)
                begin
                    pending_summaries.push_back(summarize_run());
                    clear_run();
                end
            end
            if (out_valid && out_ready)
            begin
                if (pending_summaries.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("%0t: result beat with none expected: %h", $realtime, out_data);
                end
                else
                begin
                    want = pending_summaries.pop_front();
                    check_field("mean_fixed", want.mean_fixed, out_data.mean_fixed);
                    check_field("median_value", want.median_value, out_data.median_value);
                    check_field("mode_value", want.mode_value, out_data.mode_value);
                    check_field("mode_count", want.mode_count, out_data.mode_count);
                    check_field("sum_total", want.sum_total, out_data.sum_total);
                    check_field("item_total", want.item_total, out_data.item_total);
                end
            end
            owed_results <= pending_summaries.size();
        end
    end

endmodule

[sim/rating_mean_median_mode_unit_tb.sv]
// Testbench top for the rating statistics unit: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module rating_mean_median_mode_unit_tb;
    import rmmm_pkg::*;

    localparam int RUN_CAP        = 1024;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 620;
    localparam int DIR_LEN        = 23;

    // Directed runs: two empty runs, a mode tie, a stray rating inside a run and
    // one closing it, a single top rating, every rating once, and a short run.
    localparam logic [RATING_W-1:0] DIR_RATING [DIR_LEN] = '{
        4'd0, 4'd15,
        4'd1, 4'd9, 4'd9, 4'd1,
        4'd5, 4'd10, 4'd3, 4'd12,
        4'd9,
        4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
        4'd2, 4'd2, 4'd7
    };
    localparam bit DIR_LAST [DIR_LEN] = '{
        1, 1,
        0, 0, 0, 1,
        0, 0, 0, 1,
        1,
        0, 0, 0, 0, 0, 0, 0, 0, 1,
        0, 0, 1
    };

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    rmmm_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    rmmm_out_t out_data;

    int mismatch_total;
    int owed_results;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    rating_mean_median_mode_unit #(.MAX_ITEMS(RUN_CAP)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    rating_mean_median_mode_unit_checker #(.MAX_ITEMS(RUN_CAP)) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .mismatch_total (mismatch_total),
        .owed_results   (owed_results)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("rating_mean_median_mode_unit verification failed");
                $finish;
            end
        end
    end

    // Valid stays high from one beat to the next unless a gap is taken.
    task automatic send_rating(input logic [RATING_W-1:0] r, input logic lst);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= '{rating: r, last_item: lst};
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    function automatic logic [RATING_W-1:0] stray_rating();
        int v;
        v = $urandom_range(9, 15);
        return (v == 9) ? '0 : RATING_W'(v);
    endfunction

    // Most runs are short and drawn from a random window of ratings, so that
    // medians and modes vary and ties turn up; a few runs are longer.
    task automatic send_random_run();
        int                  run_len;
        int                  lo;
        int                  hi;
        logic [RATING_W-1:0] r;
        if ($urandom_range(0, 24) == 0)
        begin
            send_rating(stray_rating(), 1'b1);
        end
        else
        begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 120)
                                                  : $urandom_range(1, 30);
            lo = $urandom_range(1, 9);
            hi = $urandom_range(lo, 9);
            for (int k = 0; k < run_len; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    r = stray_rating();
                else
                    r = RATING_W'($urandom_range(lo, hi));
                send_rating(r, k == run_len - 1);
            end
        end
    endtask

    initial
    begin
        int base;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 73;
        for (int i = 0; i < DIR_LEN; i++)
        begin
            send_rating(DIR_RATING[i], DIR_LAST[i]);
        end

        base = items_sent;
        while (items_sent < base + RANDOM_ITEMS / 3)
            send_random_run();
        send_idle_pct = 73;
        recv_idle_pct = 36;
        while (items_sent < base + 2 * RANDOM_ITEMS / 3)
            send_random_run();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_sent < base + RANDOM_ITEMS)
            send_random_run();

        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_results != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_total == 0)
            $display("rating_mean_median_mode_unit verification clean");
        else
            $display("rating_mean_median_mode_unit verification failed");
        $finish;
    end

endmodule
